### src/density_fourier_accumulator_assert.svh
// ----------------------------------------------------------------------------
// Density Fourier accumulator assertion macros
// Shared property forms for the accumulator's internal checks.
// ----------------------------------------------------------------------------
`ifndef DENSITY_FOURIER_ACCUMULATOR_ASSERT_SVH
`define DENSITY_FOURIER_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define DFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/dfa_pkg.sv
// ----------------------------------------------------------------------------
// dfa_pkg
// Types and constants of the density Fourier accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package dfa_pkg;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_ACC  = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;
	localparam logic [1:0] REQ_NONE = 2'd3;

	localparam logic [2:0] REG_FIRST = 3'd0;
	localparam logic [2:0] REG_LAST  = 3'd4;

	localparam logic [30:0] C1 = 31'd1686629713;
	localparam logic [30:0] C3 = 31'd693598668;
	localparam logic [30:0] C5 = 31'd85569306;
	localparam logic [30:0] C7 = 31'd5026995;
	localparam logic [30:0] C9 = 31'd172272;
	localparam logic [30:0] Q30_ONE = 31'd1073741824;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [5:0]         frame_index;
		logic [7:0]         vector_index;
		logic signed [15:0] wave_x;
		logic signed [15:0] wave_y;
		logic signed [15:0] wave_z;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic [5:0]         out_frame;
		logic [7:0]         out_vector;
		logic signed [31:0] real_sum;
		logic signed [31:0] imag_sum;
		logic [15:0]        atom_count;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COUNT,
		ST_ACC,
		ST_DRAIN,
		ST_READ
	} dfa_state_t;

	typedef struct packed {
		logic clr_step;
		logic load_wr;
		logic acc_start;
		logic cnt_wr;
		logic vec_issue;
		logic rd_start;
		logic out_load;
	} dfa_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic range_empty;
		logic vec_last;
		logic pipe_busy;
		logic frame_ok;
		logic out_hold;
	} dfa_sts_t;

endpackage

`default_nettype wire

### src/dfa_ctrl.sv
// ----------------------------------------------------------------------------
// dfa_ctrl
// Sequencer: clearing pass, request dispatch, vector sweep and drain.
// ----------------------------------------------------------------------------
`default_nettype none

module dfa_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [1:0]      req_type,
	input  wire dfa_pkg::dfa_sts_t sts,
	output dfa_pkg::dfa_cmd_t    cmd,
	output logic                 in_stall
);
	import dfa_pkg::*;

	dfa_state_t state_q, state_nxt;
	logic       take;

	assign take = (state_q == ST_IDLE) && in_valid && !sts.out_hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: if (sts.clr_done) state_nxt = ST_IDLE;
			ST_IDLE: begin
				if (take && req_type == REQ_ACC && sts.frame_ok) state_nxt = ST_COUNT;
				else if (take && req_type == REQ_READ) state_nxt = ST_READ;
			end
			ST_COUNT: state_nxt = sts.range_empty ? ST_IDLE : ST_ACC;
			ST_ACC: if (sts.vec_last) state_nxt = ST_DRAIN;
			ST_DRAIN: if (!sts.pipe_busy) state_nxt = ST_IDLE;
			ST_READ: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_stall = sts.out_hold;
				cmd.load_wr   = take && req_type == REQ_LOAD;
				cmd.acc_start = take && req_type == REQ_ACC && sts.frame_ok;
				cmd.rd_start  = take && req_type == REQ_READ;
			end
			ST_COUNT: cmd.cnt_wr = 1'b1;
			ST_ACC: cmd.vec_issue = 1'b1;
			ST_DRAIN: cmd = '0;
			ST_READ: cmd.out_load = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

### src/dfa_datapath.sv
// ----------------------------------------------------------------------------
// dfa_datapath
// Wave table, phase and sine pipeline, accumulator and count memories.
// ----------------------------------------------------------------------------
`default_nettype none

`include "density_fourier_accumulator_assert.svh"

module dfa_datapath #(
	parameter int FRAMES    = 64,
	parameter int VECTORS   = 256,
	parameter int TRIG_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dfa_pkg::dfa_cmd_t cmd,
	output dfa_pkg::dfa_sts_t      sts,
	input  wire dfa_pkg::in_item_t in_item,
	input  wire logic [7:0]        first_vector,
	input  wire logic [7:0]        last_vector,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output dfa_pkg::out_item_t     out_item
);
	import dfa_pkg::*;

	localparam int DEPTH = FRAMES * VECTORS;
	localparam int VW = (VECTORS > 1) ? $clog2(VECTORS) : 1;
	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NS = 10;

	function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
			logic signed [15:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s > 33'sd2147483647) return 32'sh7FFFFFFF;
		if (s < -33'sd2147483648) return 32'sh80000000;
		return s[31:0];
	endfunction

	logic [47:0]  tbl_mem [VECTORS];
	logic [63:0]  sums_mem [DEPTH];
	logic [15:0]  cnt_mem [FRAMES];

	logic [AW-1:0] clr_q;
	logic [7:0]    vcnt_q;
	logic [FW-1:0] frame_q;
	logic signed [23:0] px_q, py_q, pz_q;
	logic [15:0]   cnt_rd_q;
	logic [63:0]   sums_rd_q;
	logic [5:0]    rd_frame_q;
	logic [7:0]    rd_vec_q;
	logic          rd_fok_q, rd_vok_q;
	logic          out_valid_q;
	out_item_t     out_q;

	logic          vld_q [1:NS];
	logic [AW-1:0] slot_q [1:NS];
	logic [1:0]    quad_q [3:9];

	logic [47:0]        tbl_s1;
	logic signed [39:0] prx_s2, pry_s2, prz_s2;
	logic [30:0]        x_s3 [2];
	logic [61:0]        m_s4 [2];
	logic [30:0]        x_s4 [2];
	logic [30:0]        x2_s5 [2], x2_s6 [2], x2_s7 [2];
	logic [61:0]        m_s5 [2], m_s6 [2], m_s7 [2], m_s8 [2], m_s9 [2];
	logic [30:0]        x_s5 [2], x_s6 [2], x_s7 [2], x_s8 [2];
	logic signed [15:0] cos_s10, sin_s10;

	logic          in_fok, in_vok;
	logic [AW-1:0] in_slot, issue_slot, sums_raddr;
	logic [19:0]   frac;
	logic [TRIG_BITS-1:0] idx;
	logic [30:0]   xa;
	logic [30:0]   t6 [2], t7 [2], t8 [2], t9 [2];
	logic [15:0]   y [2];
	logic [31:0]   yr [2];
	logic          pipe_any;

	assign in_fok = 32'(in_item.frame_index) < FRAMES;
	assign in_vok = 32'(in_item.vector_index) < VECTORS;
	assign in_slot = AW'(AW'(in_item.frame_index) * AW'(VECTORS)) + AW'(in_item.vector_index);
	assign issue_slot = AW'(AW'(frame_q) * AW'(VECTORS)) + AW'(vcnt_q);
	assign sums_raddr = cmd.rd_start ? in_slot : slot_q[9];

	always_comb begin
		pipe_any = 1'b0;
		for (int i = 1; i <= NS; i++) pipe_any = pipe_any | vld_q[i];
	end

	assign sts.clr_done    = clr_q == AW'(DEPTH - 1);
	assign sts.range_empty = (first_vector > last_vector) || (32'(first_vector) >= VECTORS);
	assign sts.vec_last    = (vcnt_q == last_vector) || (32'(vcnt_q) == VECTORS - 1);
	assign sts.pipe_busy   = pipe_any;
	assign sts.frame_ok    = in_fok;
	assign sts.out_hold    = out_valid_q && out_stall;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 1; i <= NS; i++) vld_q[i] <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			vld_q[1] <= cmd.vec_issue;
			for (int i = 2; i <= NS; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.acc_start) begin
			frame_q <= FW'(in_item.frame_index);
			px_q <= in_item.pos_x;
			py_q <= in_item.pos_y;
			pz_q <= in_item.pos_z;
			vcnt_q <= first_vector;
		end else if (cmd.vec_issue) begin
			vcnt_q <= vcnt_q + 8'd1;
		end
		if (cmd.rd_start) begin
			rd_frame_q <= in_item.frame_index;
			rd_vec_q <= in_item.vector_index;
			rd_fok_q <= in_fok;
			rd_vok_q <= in_vok;
		end
		if (cmd.out_load) begin
			out_q.out_frame  <= rd_frame_q;
			out_q.out_vector <= rd_vec_q;
			out_q.real_sum   <= (rd_fok_q && rd_vok_q) ? sums_rd_q[63:32] : '0;
			out_q.imag_sum   <= (rd_fok_q && rd_vok_q) ? sums_rd_q[31:0] : '0;
			out_q.atom_count <= rd_fok_q ? cnt_rd_q : '0;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.load_wr && in_vok)
			tbl_mem[VW'(in_item.vector_index)] <= {in_item.wave_x, in_item.wave_y,
				in_item.wave_z};
		if (cmd.vec_issue) tbl_s1 <= tbl_mem[VW'(vcnt_q)];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step && clr_q <= AW'(FRAMES - 1)) cnt_mem[FW'(clr_q)] <= '0;
		else if (cmd.cnt_wr)
			cnt_mem[frame_q] <= (cnt_rd_q == 16'hFFFF) ? cnt_rd_q : cnt_rd_q + 16'd1;
		if (cmd.acc_start || cmd.rd_start) cnt_rd_q <= cnt_mem[FW'(in_item.frame_index)];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) sums_mem[clr_q] <= '0;
		else if (vld_q[NS])
			sums_mem[slot_q[NS]] <= {sat_add(sums_rd_q[63:32], cos_s10),
				sat_add(sums_rd_q[31:0], sin_s10)};
		if (cmd.rd_start || vld_q[9]) sums_rd_q <= sums_mem[sums_raddr];
	end

	// phase and quarter sine pipeline
	assign frac = prx_s2[19:0] + pry_s2[19:0] + prz_s2[19:0];
	assign idx = TRIG_BITS'({frac, 4'b0000} >> (24 - TRIG_BITS));
	assign xa = 31'(idx[TRIG_BITS-3:0]) << (32 - TRIG_BITS);

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			t6[l] = C7 - m_s5[l][60:30];
			t7[l] = C5 - m_s6[l][60:30];
			t8[l] = C3 - m_s7[l][60:30];
			t9[l] = C1 - m_s8[l][60:30];
			yr[l] = (32'(m_s9[l][60:30]) + 32'd32768) >> 16;
			y[l] = (yr[l] > 32'd16384) ? 16'd16384 : yr[l][15:0];
		end
	end

	always_ff @(posedge clk) begin
		slot_q[1] <= issue_slot;
		for (int i = 2; i <= NS; i++) slot_q[i] <= slot_q[i-1];
		prx_s2 <= $signed(tbl_s1[47:32]) * px_q;
		pry_s2 <= $signed(tbl_s1[31:16]) * py_q;
		prz_s2 <= $signed(tbl_s1[15:0]) * pz_q;
		quad_q[3] <= idx[TRIG_BITS-1:TRIG_BITS-2];
		for (int i = 4; i <= 9; i++) quad_q[i] <= quad_q[i-1];
		x_s3[0] <= xa;
		x_s3[1] <= Q30_ONE - xa;
		for (int l = 0; l < 2; l++) begin
			m_s4[l]  <= 62'(x_s3[l]) * 62'(x_s3[l]);
			x_s4[l]  <= x_s3[l];
			x2_s5[l] <= m_s4[l][60:30];
			m_s5[l]  <= 62'(m_s4[l][60:30]) * 62'(C9);
			x_s5[l]  <= x_s4[l];
			x2_s6[l] <= x2_s5[l];
			m_s6[l]  <= 62'(x2_s5[l]) * 62'(t6[l]);
			x_s6[l]  <= x_s5[l];
			x2_s7[l] <= x2_s6[l];
			m_s7[l]  <= 62'(x2_s6[l]) * 62'(t7[l]);
			x_s7[l]  <= x_s6[l];
			m_s8[l]  <= 62'(x2_s7[l]) * 62'(t8[l]);
			x_s8[l]  <= x_s7[l];
			m_s9[l]  <= 62'(x_s8[l]) * 62'(t9[l]);
		end
		unique case (quad_q[9])
			2'd0: begin sin_s10 <= $signed(y[0]); cos_s10 <= $signed(y[1]); end
			2'd1: begin sin_s10 <= $signed(y[1]); cos_s10 <= -$signed(y[0]); end
			2'd2: begin sin_s10 <= -$signed(y[0]); cos_s10 <= -$signed(y[1]); end
			default: begin sin_s10 <= -$signed(y[1]); cos_s10 <= $signed(y[0]); end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	`DFA_ASSERT_NOW(a_rd_idle_pipe, cmd.rd_start, !pipe_any, "read issued during sweep")
	`DFA_ASSERT_NOW(a_clr_excl, cmd.clr_step, !pipe_any && !cmd.cnt_wr, "clear overlaps update")
	`DFA_ASSERT_NEXT(a_out_load, cmd.out_load, out_valid_q, "loaded result not presented")

endmodule

`default_nettype wire

### src/density_fourier_accumulator.sv
// ----------------------------------------------------------------------------
// density_fourier_accumulator
// Fixed-point accumulator of the density Fourier transform per frame and vector.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the FRAMES*VECTORS words (16384 at
// the default sizes) of the accumulator memory before it takes its first
// request; register writes are taken meanwhile. A load writes one wave table entry.
// A read presents one result in an output register. An accumulate counts the
// atom in its frame and, unless the range of wave vectors is empty, sweeps it:
// one vector a cycle enters the shared phase and sine pipeline, whose ten
// stages end in a read-modify-write of the single accumulator memory, and the
// pipeline drains before the next request.
`default_nettype none

module density_fourier_accumulator #(
	parameter int FRAMES    = 64,
	parameter int VECTORS   = 256,
	parameter int TRIG_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire dfa_pkg::in_item_t in_item,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output dfa_pkg::out_item_t    out_item,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import dfa_pkg::*;

	logic [7:0] first_q, last_q;
	dfa_cmd_t   cmd;
	dfa_sts_t   sts;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? {24'd0, last_q} : {24'd0, first_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 8'd0;
			last_q  <= 8'd255;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) last_q <= pwdata[7:0];
			else first_q <= pwdata[7:0];
		end
	end

	dfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (in_item.req_type),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	dfa_datapath #(
		.FRAMES    (FRAMES),
		.VECTORS   (VECTORS),
		.TRIG_BITS (TRIG_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_item      (in_item),
		.first_vector (first_q),
		.last_vector  (last_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_item     (out_item)
	);

endmodule

`default_nettype wire
